// ===== hdl/rgbhls_pkg.sv =====
package rgbhls_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 4;

    localparam int HUE_W    = 13;
    localparam int LIGHT_W  = 9;
    localparam int SAT_W    = 13;
    localparam int SAT_FRAC = 12;
    localparam int DEG_SIXTY = 60;

    localparam int M_TDATA_W = ((HUE_W + LIGHT_W + SAT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_sel_t;

    typedef struct packed {
        logic                achro;
        logic                neg;
        chan_sel_t           sel;
        logic [LIGHT_W-1:0]  light;
    } hls_side_t;

endpackage

// ===== hdl/rgb_to_hls_convert_core.sv =====
// Pipeline, independent of CHANNEL_BITS: two front stages, one divider cell per
// quotient bit, one output register.
// Throughput: one beat per cycle; the whole chain advances whenever the output
// register is empty or being taken, so a stall on m_tready holds every stage.
// Reset (aresetn, synchronous, active low) clears the valid bits only.
module rgb_to_hls_convert_core #(
    parameter int CHANNEL_BITS      = rgbhls_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhls_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // red, green, blue
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // hue, lightness_x2, saturation
    output logic [rgbhls_pkg::M_TDATA_W-1:0]        m_tdata,
    // achromatic
    output logic                                    m_tuser
);
    import rgbhls_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int HUE_Q  = 6 + HUE_FRACTION_BITS;
    localparam int STAGES = (SAT_W > HUE_Q) ? SAT_W : HUE_Q;
    localparam int SAT_DW = CB + 1;
    localparam int SAT_RW = SAT_DW + STAGES;
    localparam int HUE_DW = CB;
    localparam int HUE_RW = HUE_DW + STAGES;
    localparam int OUT_PAD = M_TDATA_W - HUE_W - LIGHT_W - SAT_W;

    logic en;

    logic              vld     [STAGES+1];
    logic [SAT_RW-1:0] sat_rem [STAGES+1];
    logic [SAT_DW-1:0] sat_den [STAGES+1];
    logic [STAGES-1:0] sat_q   [STAGES+1];
    logic [HUE_RW-1:0] hue_rem [STAGES+1];
    logic [HUE_DW-1:0] hue_den [STAGES+1];
    logic [STAGES-1:0] hue_q   [STAGES+1];
    hls_side_t         side    [STAGES+1];

    logic [HUE_W-1:0]   hue;
    logic [LIGHT_W-1:0] lightness_x2;
    logic [SAT_W-1:0]   saturation;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rgbhls_front #(
        .CHANNEL_BITS      (CB),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .SAT_RW            (SAT_RW),
        .HUE_RW            (HUE_RW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[CB-1:0]),
        .green     (s_tdata[2*CB-1:CB]),
        .blue      (s_tdata[3*CB-1:2*CB]),
        .out_valid (vld[0]),
        .sat_num   (sat_rem[0]),
        .sat_den   (sat_den[0]),
        .hue_num   (hue_rem[0]),
        .hue_den   (hue_den[0]),
        .side      (side[0])
    );

    assign sat_q[0] = '0;
    assign hue_q[0] = '0;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        rgbhls_cell #(
            .SAT_DW (SAT_DW),
            .SAT_RW (SAT_RW),
            .HUE_DW (HUE_DW),
            .HUE_RW (HUE_RW),
            .QW     (STAGES),
            .BIT    (STAGES - 1 - i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .in_valid    (vld[i]),
            .sat_rem_in  (sat_rem[i]),
            .sat_den_in  (sat_den[i]),
            .sat_q_in    (sat_q[i]),
            .hue_rem_in  (hue_rem[i]),
            .hue_den_in  (hue_den[i]),
            .hue_q_in    (hue_q[i]),
            .side_in     (side[i]),
            .out_valid   (vld[i+1]),
            .sat_rem_out (sat_rem[i+1]),
            .sat_den_out (sat_den[i+1]),
            .sat_q_out   (sat_q[i+1]),
            .hue_rem_out (hue_rem[i+1]),
            .hue_den_out (hue_den[i+1]),
            .hue_q_out   (hue_q[i+1]),
            .side_out    (side[i+1])
        );
    end

    rgbhls_back #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QW                (STAGES),
        .HUE_Q             (HUE_Q)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (vld[STAGES]),
        .sat_q        (sat_q[STAGES]),
        .hue_q        (hue_q[STAGES]),
        .side         (side[STAGES]),
        .m_valid      (m_tvalid),
        .hue          (hue),
        .lightness_x2 (lightness_x2),
        .saturation   (saturation),
        .achromatic   (m_tuser)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, saturation, lightness_x2, hue};

endmodule

// ===== hdl/rgbhls_front.sv =====
module rgbhls_front #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 4,
    parameter int SAT_RW            = 22,
    parameter int HUE_RW            = 21
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [CHANNEL_BITS-1:0]      red,
    input  logic [CHANNEL_BITS-1:0]      green,
    input  logic [CHANNEL_BITS-1:0]      blue,
    output logic                         out_valid,
    output logic [SAT_RW-1:0]            sat_num,
    output logic [CHANNEL_BITS:0]        sat_den,
    output logic [HUE_RW-1:0]            hue_num,
    output logic [CHANNEL_BITS-1:0]      hue_den,
    output rgbhls_pkg::hls_side_t        side
);
    import rgbhls_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int SIXTY = DEG_SIXTY << HUE_FRACTION_BITS;
    localparam logic [CB+1:0] FULL = (CB+2)'((1 << CB) - 1);

    logic [CB-1:0]  mx, mn, d, mag;
    logic [CB:0]    s;
    logic [CB+1:0]  den_wide;
    logic           neg;
    chan_sel_t      sel;
    hls_side_t      side1_next;

    logic           v1_reg;
    logic [CB-1:0]  mag1_reg, d1_reg;
    logic [CB:0]    den1_reg;
    hls_side_t      side1_reg;

    logic           v2_reg;
    logic [SAT_RW-1:0] sat_num2_reg;
    logic [HUE_RW-1:0] hue_num2_reg;
    logic [CB:0]       den2_reg;
    logic [CB-1:0]     d2_reg;
    hls_side_t         side2_reg;

    always_comb begin
        if (red >= green && red >= blue) begin
            sel = CH_RED;
            mx  = red;
        end else if (green >= blue) begin
            sel = CH_GREEN;
            mx  = green;
        end else begin
            sel = CH_BLUE;
            mx  = blue;
        end
        mn = (red < green) ? red : green;
        mn = (blue < mn) ? blue : mn;
        d  = mx - mn;
        s  = {1'b0, mx} + {1'b0, mn};
        case (sel)
            CH_RED: begin
                neg = green < blue;
                mag = neg ? blue - green : green - blue;
            end
            CH_GREEN: begin
                neg = blue < red;
                mag = neg ? red - blue : blue - red;
            end
            CH_BLUE: begin
                neg = red < green;
                mag = neg ? green - red : red - green;
            end
            default: begin
                neg = 1'b0;
                mag = '0;
            end
        endcase
        den_wide = ({1'b0, s} < FULL) ? {1'b0, s} : (FULL << 1) - {1'b0, s};
        side1_next.achro = (d == '0);
        side1_next.neg   = neg;
        side1_next.sel   = sel;
        side1_next.light = LIGHT_W'(s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg     <= mag;
            d1_reg       <= d;
            den1_reg     <= den_wide[CB:0];
            side1_reg    <= side1_next;
            sat_num2_reg <= SAT_RW'(d1_reg) << SAT_FRAC;
            hue_num2_reg <= HUE_RW'(mag1_reg) * HUE_RW'(SIXTY);
            den2_reg     <= den1_reg;
            d2_reg       <= d1_reg;
            side2_reg    <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign sat_num   = sat_num2_reg;
    assign sat_den   = den2_reg;
    assign hue_num   = hue_num2_reg;
    assign hue_den   = d2_reg;
    assign side      = side2_reg;

endmodule

// ===== hdl/rgbhls_cell.sv =====
module rgbhls_cell #(
    parameter int SAT_DW = 9,
    parameter int SAT_RW = 22,
    parameter int HUE_DW = 8,
    parameter int HUE_RW = 21,
    parameter int QW     = 13,
    parameter int BIT    = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [SAT_RW-1:0]      sat_rem_in,
    input  logic [SAT_DW-1:0]      sat_den_in,
    input  logic [QW-1:0]          sat_q_in,
    input  logic [HUE_RW-1:0]      hue_rem_in,
    input  logic [HUE_DW-1:0]      hue_den_in,
    input  logic [QW-1:0]          hue_q_in,
    input  rgbhls_pkg::hls_side_t  side_in,
    output logic                   out_valid,
    output logic [SAT_RW-1:0]      sat_rem_out,
    output logic [SAT_DW-1:0]      sat_den_out,
    output logic [QW-1:0]          sat_q_out,
    output logic [HUE_RW-1:0]      hue_rem_out,
    output logic [HUE_DW-1:0]      hue_den_out,
    output logic [QW-1:0]          hue_q_out,
    output rgbhls_pkg::hls_side_t  side_out
);
    import rgbhls_pkg::*;

    logic [SAT_RW-1:0] sat_trial;
    logic [HUE_RW-1:0] hue_trial;
    logic              sat_ge, hue_ge;
    logic [SAT_RW-1:0] sat_rem_next;
    logic [HUE_RW-1:0] hue_rem_next;
    logic [QW-1:0]     sat_q_next, hue_q_next;

    logic              valid_reg;
    logic [SAT_RW-1:0] sat_rem_reg;
    logic [SAT_DW-1:0] sat_den_reg;
    logic [QW-1:0]     sat_q_reg;
    logic [HUE_RW-1:0] hue_rem_reg;
    logic [HUE_DW-1:0] hue_den_reg;
    logic [QW-1:0]     hue_q_reg;
    hls_side_t         side_reg;

    // restoring step for quotient weight 2^BIT
    always_comb begin
        sat_trial    = SAT_RW'(sat_den_in) << BIT;
        hue_trial    = HUE_RW'(hue_den_in) << BIT;
        sat_ge       = sat_rem_in >= sat_trial;
        hue_ge       = hue_rem_in >= hue_trial;
        sat_rem_next = sat_ge ? sat_rem_in - sat_trial : sat_rem_in;
        hue_rem_next = hue_ge ? hue_rem_in - hue_trial : hue_rem_in;
        sat_q_next      = sat_q_in;
        sat_q_next[BIT] = sat_ge;
        hue_q_next      = hue_q_in;
        hue_q_next[BIT] = hue_ge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_rem_reg <= sat_rem_next;
            sat_den_reg <= sat_den_in;
            sat_q_reg   <= sat_q_next;
            hue_rem_reg <= hue_rem_next;
            hue_den_reg <= hue_den_in;
            hue_q_reg   <= hue_q_next;
            side_reg    <= side_in;
        end
    end

    assign out_valid   = valid_reg;
    assign sat_rem_out = sat_rem_reg;
    assign sat_den_out = sat_den_reg;
    assign sat_q_out   = sat_q_reg;
    assign hue_rem_out = hue_rem_reg;
    assign hue_den_out = hue_den_reg;
    assign hue_q_out   = hue_q_reg;
    assign side_out    = side_reg;

endmodule

// ===== hdl/rgbhls_back.sv =====
module rgbhls_back #(
    parameter int HUE_FRACTION_BITS = 4,
    parameter int QW                = 13,
    parameter int HUE_Q             = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [QW-1:0]                     sat_q,
    input  logic [QW-1:0]                     hue_q,
    input  rgbhls_pkg::hls_side_t             side,
    output logic                              m_valid,
    output logic [rgbhls_pkg::HUE_W-1:0]      hue,
    output logic [rgbhls_pkg::LIGHT_W-1:0]    lightness_x2,
    output logic [rgbhls_pkg::SAT_W-1:0]      saturation,
    output logic                              achromatic
);
    import rgbhls_pkg::*;

    localparam int SIXTY   = DEG_SIXTY << HUE_FRACTION_BITS;
    localparam int ONE_DEG = 1 << HUE_FRACTION_BITS;
    localparam int HSW     = HUE_W + HUE_FRACTION_BITS + 2;

    logic signed [HSW-1:0] base, off, h_raw, h_wrap;
    logic [HUE_W-1:0]      hue_next;
    logic [SAT_W-1:0]      sat_next;

    logic                  valid_reg;
    logic [HUE_W-1:0]      hue_reg;
    logic [LIGHT_W-1:0]    light_reg;
    logic [SAT_W-1:0]      sat_reg;
    logic                  achro_reg;

    always_comb begin
        case (side.sel)
            CH_RED:   base = '0;
            CH_GREEN: base = HSW'(2 * SIXTY);
            CH_BLUE:  base = HSW'(4 * SIXTY);
            default:  base = '0;
        endcase
        off    = $signed({{(HSW-HUE_Q){1'b0}}, hue_q[HUE_Q-1:0]});
        h_raw  = side.neg ? base - off : base + off;
        h_wrap = (h_raw < 0) ? h_raw + HSW'(6 * SIXTY) : h_raw;
        hue_next = side.achro ? HUE_W'(ONE_DEG) : h_wrap[HUE_W-1:0];
        sat_next = side.achro ? '0 : sat_q[SAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg   <= hue_next;
            light_reg <= side.light;
            sat_reg   <= sat_next;
            achro_reg <= side.achro;
        end
    end

    assign m_valid      = valid_reg;
    assign hue          = hue_reg;
    assign lightness_x2 = light_reg;
    assign saturation   = sat_reg;
    assign achromatic   = achro_reg;

endmodule

// ===== tb/rgb_hls_checker.sv =====
module rgb_hls_checker (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                s_tvalid,
    input  logic                                                s_tready,
    input  logic [((3*rgbhls_pkg::CHANNEL_BITS_DEF+7)/8)*8-1:0] s_tdata,
    input  logic                                                m_tvalid,
    input  logic                                                m_tready,
    input  logic [rgbhls_pkg::M_TDATA_W-1:0]                    m_tdata,
    input  logic                                                m_tuser,
    output int                                                  results_checked,
    output int                                                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhls_pkg::*;

    localparam int CB = CHANNEL_BITS_DEF;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LIGHT_W-1:0] light;
        logic [SAT_W-1:0]   sat;
        logic               achro;
    } hls_pixel_t;

    hls_pixel_t hls_expected[$];

    function automatic hls_pixel_t predict_hls(input logic [CB-1:0] r, g, b);
        int         rv, gv, bv, mx, mn, d, s, h, sixty, full;
        hls_pixel_t p;
        rv    = r;
        gv    = g;
        bv    = b;
        full  = (1 << CB) - 1;
        sixty = DEG_SIXTY << HUE_FRACTION_BITS_DEF;
        mx    = (rv > gv) ? rv : gv;
        mx    = (bv > mx) ? bv : mx;
        mn    = (rv < gv) ? rv : gv;
        mn    = (bv < mn) ? bv : mn;
        d     = mx - mn;
        s     = mx + mn;
        p.light = LIGHT_W'(s);
        if (d == 0) begin
            p.achro = 1'b1;
            p.hue   = HUE_W'(1 << HUE_FRACTION_BITS_DEF);
            p.sat   = '0;
        end else begin
            p.achro = 1'b0;
            p.sat   = SAT_W'((d << SAT_FRAC) / ((s < full) ? s : 2 * full - s));
            // signed int division truncates toward zero
            if (rv == mx)
                h = ((gv - bv) * sixty) / d;
            else if (gv == mx)
                h = 2 * sixty + ((bv - rv) * sixty) / d;
            else
                h = 4 * sixty + ((rv - gv) * sixty) / d;
            if (h < 0)
                h += 6 * sixty;
            p.hue = HUE_W'(h);
        end
        return p;
    endfunction

    always @(posedge aclk) begin
        hls_pixel_t want;
        logic [HUE_W-1:0]   got_hue;
        logic [LIGHT_W-1:0] got_light;
        logic [SAT_W-1:0]   got_sat;
        int                 errs;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                hls_expected.push_back(predict_hls(s_tdata[0 +: CB], s_tdata[CB +: CB],
                                                   s_tdata[2*CB +: CB]));
            if (m_tvalid && m_tready) begin
                if (hls_expected.size() == 0) begin
                    $error("unexpected result beat: tdata %h tuser %b", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want      = hls_expected.pop_front();
                    got_hue   = m_tdata[0 +: HUE_W];
                    got_light = m_tdata[HUE_W +: LIGHT_W];
                    got_sat   = m_tdata[HUE_W + LIGHT_W +: SAT_W];
                    errs      = 0;
                    if (got_hue !== want.hue) begin
                        $error("hue mismatch: expected %0d, got %0d", want.hue, got_hue);
                        errs++;
                    end
                    if (got_light !== want.light) begin
                        $error("lightness_x2 mismatch: expected %0d, got %0d",
                               want.light, got_light);
                        errs++;
                    end
                    if (got_sat !== want.sat) begin
                        $error("saturation mismatch: expected %0d, got %0d", want.sat, got_sat);
                        errs++;
                    end
                    if (m_tuser !== want.achro) begin
                        $error("achromatic mismatch: expected %0d, got %0d", want.achro, m_tuser);
                        errs++;
                    end
                    if (errs != 0)
                        fail_count <= fail_count + 1;
                    results_checked <= results_checked + 1;
                end
            end
        end
    end

endmodule

// ===== tb/tb_rgb_to_hls_convert_core.sv =====
module tb_rgb_to_hls_convert_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhls_pkg::*;

    localparam int CB          = CHANNEL_BITS_DEF;
    localparam int S_W         = ((3 * CB + 7) / 8) * 8;
    localparam int RANDOM_PIX  = 900;
    localparam int CALM_TAIL   = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 24;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int results_checked;
    int fail_count;
    int pixels_sent = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit gaps_on     = 1'b0;
    bit stalls_on   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_to_hls_convert_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rgb_hls_checker u_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .results_checked (results_checked),
        .fail_count      (fail_count)
    );

    // result-side backpressure in random bursts, started while stalls_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic drive_pixel(input logic [CB-1:0] r, g, b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({b, g, r});
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_checked != pixels_sent) @(posedge aclk);
    endtask

    task automatic drive_random_pixel();
        logic [CB-1:0] r, g, b;
        r = CB'($urandom);
        g = CB'($urandom);
        b = CB'($urandom);
        case ($urandom_range(0, 9))
            0, 1: begin
                g = r;
                b = r;
            end
            2: g = r;
            3: b = g;
            4: b = r;
            5: begin
                r = ($urandom_range(0, 1) != 0) ? '1 : '0;
                g = CB'($urandom_range(0, 3));
                b = ~CB'($urandom_range(0, 3));
            end
            default: ;
        endcase
        drive_pixel(r, g, b);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        drive_pixel(8'd0,   8'd0,   8'd0);
        drive_pixel(8'd255, 8'd255, 8'd255);
        drive_pixel(8'd128, 8'd128, 8'd128);
        drive_pixel(8'd255, 8'd0,   8'd0);
        drive_pixel(8'd0,   8'd255, 8'd0);
        drive_pixel(8'd0,   8'd0,   8'd255);
        drive_pixel(8'd255, 8'd255, 8'd0);
        drive_pixel(8'd0,   8'd255, 8'd255);
        drive_pixel(8'd255, 8'd0,   8'd255);
        drive_pixel(8'd100, 8'd50,  8'd20);
        drive_pixel(8'd200, 8'd150, 8'd100);
        drive_pixel(8'd200, 8'd55,  8'd100);
        drive_pixel(8'd254, 8'd0,   8'd0);
        drive_pixel(8'd200, 8'd10,  8'd50);
        drive_pixel(8'd1,   8'd0,   8'd0);
        drive_pixel(8'd255, 8'd254, 8'd254);
        drive_pixel(8'd20,  8'd90,  8'd200);
        drive_pixel(8'd90,  8'd200, 8'd20);
        drive_pixel(8'hAA,  8'h55,  8'hAA);
        drive_pixel(8'h55,  8'hAA,  8'h55);
        wait_drained();

        for (int i = 0; i < RANDOM_PIX; i++) begin
            if (i % 64 == 0) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (i >= RANDOM_PIX - CALM_TAIL) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (i == RANDOM_PIX / 2)
                wait_drained();
            drive_random_pixel();
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && results_checked == pixels_sent)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
